### hdl/oiuf_pkg.sv
// oiuf_pkg: shared constants for the online island union-find block
// field widths, register indexes and parameter defaults
// no dependencies
`default_nettype none

package oiuf_pkg;

    // default grid bounds for storage sizing
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // payload widths
    localparam int COORD_W = 6;
    localparam int COUNT_W = 13;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;

    // bus widths, padded to whole bytes
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    // register reset values
    localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

endpackage

`default_nettype wire

### hdl/online_island_union_find.sv
// online_island_union_find: online count of 4-connected land components on a grid
// union-find with path compression, parent table and land bit held in one ram
// depends on oiuf_pkg and oiuf_ram
//
//  channel   | signals                                  | direction
//  ----------+------------------------------------------+----------
//  s_axis    | tvalid, tready, tdata (cell_row, col)    | in
//  m_axis    | tvalid, tready, tdata (count), tuser     | out
//  cfg       | valid, ready, index, data                | in
//
// after reset a clearing pass writes every cell, with no input transfer taken;
// configuration writes are taken at any time.
// an out-of-range or already-land cell goes straight to the result; a new cell is
// marked land and then, per neighbour position, one off the grid or water is skipped,
// and for land both finds walk their parent chains, compress each walked chain and
// link the roots if they differ, all through the single ram port.
// one item is in work at a time; a finished result waits in the output register
// and the next item is taken once it has been loaded there.
`default_nettype none

module online_island_union_find
    import oiuf_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cell_row[5:0], cell_col[11:6]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // island_count[12:0]
    output logic                        m_axis_tuser,   // out_of_range[0]
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int WW    = AW + 1;

    // sequencer codes
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_NB    = 4'd3;
    localparam logic [3:0] S_NBCHK = 4'd4;
    localparam logic [3:0] S_START = 4'd5;
    localparam logic [3:0] S_FIND  = 4'd6;
    localparam logic [3:0] S_COMP  = 4'd7;
    localparam logic [3:0] S_LINK  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [CFG_W-1:0]   grid_rows_reg, grid_cols_reg;
    logic [CFG_W-1:0]   rows_reg, rows_next, cols_reg, cols_next;
    logic [COORD_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [AW-1:0]      here_reg, here_next;
    logic [AW-1:0]      nb_reg, nb_next;
    logic [AW-1:0]      walk_reg, walk_next;
    logic [AW-1:0]      start_reg, start_next;
    logic [AW-1:0]      root_reg, root_next;
    logic [AW-1:0]      ra_reg, ra_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [2:0]         nb_idx_reg, nb_idx_next;
    logic               phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               oor_reg, oor_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_oor_reg, out_oor_next;

    // ram interface
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0] ram_wdata, ram_rdata;
    logic          rd_land;
    logic [AW-1:0] rd_parent;

    // input decode
    logic [COORD_W-1:0] in_row, in_col;
    logic [CFG_W-1:0]   rows_eff, cols_eff;
    logic [AW-1:0]      in_here;
    logic               in_oor;

    // neighbour decode
    logic          nb_exists;
    logic [AW-1:0] nb_addr;

    // find completion
    logic          find_done;
    logic [AW-1:0] find_root;

    assign in_row   = s_axis_tdata[COORD_W-1:0];
    assign in_col   = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign rows_eff = (32'(grid_rows_reg) < MAX_ROWS) ? grid_rows_reg : CFG_W'(MAX_ROWS);
    assign cols_eff = (32'(grid_cols_reg) < MAX_COLS) ? grid_cols_reg : CFG_W'(MAX_COLS);
    assign in_oor   = (CFG_W'(in_row) >= rows_eff) || (CFG_W'(in_col) >= cols_eff);
    assign in_here  = AW'(32'(in_row) * MAX_COLS + 32'(in_col));

    assign rd_land   = ram_rdata[AW];
    assign rd_parent = ram_rdata[AW-1:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_count_reg);
    assign m_axis_tuser  = out_oor_reg;

    // neighbour order: up, down, left, right
    always_comb
    begin
        nb_exists = 1'b0;
        nb_addr   = here_reg;
        case (nb_idx_reg)
            3'd0:
            begin
                nb_exists = (row_reg != '0);
                nb_addr   = AW'(32'(here_reg) - MAX_COLS);
            end
            3'd1:
            begin
                nb_exists = (32'(row_reg) + 1 < 32'(rows_reg));
                nb_addr   = AW'(32'(here_reg) + MAX_COLS);
            end
            3'd2:
            begin
                nb_exists = (col_reg != '0);
                nb_addr   = AW'(32'(here_reg) - 1);
            end
            3'd3:
            begin
                nb_exists = (32'(col_reg) + 1 < 32'(cols_reg));
                nb_addr   = AW'(32'(here_reg) + 1);
            end
            default:
            begin
                nb_exists = 1'b0;
                nb_addr   = here_reg;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        here_next      = here_reg;
        nb_next        = nb_reg;
        walk_next      = walk_reg;
        start_next     = start_reg;
        root_next      = root_reg;
        ra_next        = ra_reg;
        clr_next       = clr_reg;
        nb_idx_next    = nb_idx_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_oor_next   = out_oor_reg;
        ram_we         = 1'b0;
        ram_waddr      = walk_reg;
        ram_wdata      = {1'b1, root_reg};
        ram_raddr      = walk_reg;
        find_done      = 1'b0;
        find_root      = walk_reg;

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == CELLS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_raddr = in_here;
                if (s_axis_tvalid)
                begin
                    row_next  = in_row;
                    col_next  = in_col;
                    rows_next = rows_eff;
                    cols_next = cols_eff;
                    here_next = in_here;
                    oor_next  = in_oor;
                    state_next = in_oor ? S_FIN : S_CHK;
                end
            end
            S_CHK:
            begin
                if (rd_land)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = here_reg;
                    ram_wdata   = {1'b1, here_reg};
                    count_next  = count_reg + 1'b1;
                    nb_idx_next = '0;
                    state_next  = S_NB;
                end
            end
            S_NB:
            begin
                ram_raddr = nb_addr;
                if (nb_idx_reg == 3'd4)
                begin
                    state_next = S_FIN;
                end
                else if (nb_exists)
                begin
                    nb_next    = nb_addr;
                    state_next = S_NBCHK;
                end
                else
                begin
                    nb_idx_next = nb_idx_reg + 1'b1;
                end
            end
            S_NBCHK:
            begin
                if (rd_land)
                begin
                    phase_next = 1'b0;
                    walk_next  = here_reg;
                    start_next = here_reg;
                    state_next = S_START;
                end
                else
                begin
                    nb_idx_next = nb_idx_reg + 1'b1;
                    state_next  = S_NB;
                end
            end
            S_START:
            begin
                ram_raddr  = walk_reg;
                state_next = S_FIND;
            end
            S_FIND:
            begin
                // follow parents up to the root
                if (rd_parent == walk_reg)
                begin
                    if (start_reg == walk_reg)
                    begin
                        find_done = 1'b1;
                        find_root = walk_reg;
                    end
                    else
                    begin
                        root_next  = walk_reg;
                        walk_next  = start_reg;
                        ram_raddr  = start_reg;
                        state_next = S_COMP;
                    end
                end
                else
                begin
                    walk_next = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            S_COMP:
            begin
                // point each node on the chain at the root
                ram_we    = 1'b1;
                ram_waddr = walk_reg;
                ram_wdata = {1'b1, root_reg};
                walk_next = rd_parent;
                ram_raddr = rd_parent;
                if (rd_parent == root_reg)
                begin
                    find_done = 1'b1;
                    find_root = root_reg;
                end
            end
            S_LINK:
            begin
                if (ra_reg != root_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = ra_reg;
                    ram_wdata  = {1'b1, root_reg};
                    count_next = count_reg - 1'b1;
                end
                nb_idx_next = nb_idx_reg + 1'b1;
                state_next  = S_NB;
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_oor_next   = oor_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one find finished: start the second or link the roots
        if (find_done)
        begin
            if (!phase_reg)
            begin
                ra_next    = find_root;
                phase_next = 1'b1;
                walk_next  = nb_reg;
                start_next = nb_reg;
                state_next = S_START;
            end
            else
            begin
                root_next  = find_root;
                state_next = S_LINK;
            end
        end
    end

    // control, count and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            grid_rows_reg <= GRID_RESET;
            grid_cols_reg <= GRID_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            // configuration transfer
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                    REG_GRID_COLS: grid_cols_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg      <= rows_next;
        cols_reg      <= cols_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        here_reg      <= here_next;
        nb_reg        <= nb_next;
        walk_reg      <= walk_next;
        start_reg     <= start_next;
        root_reg      <= root_next;
        ra_reg        <= ra_next;
        nb_idx_reg    <= nb_idx_next;
        phase_reg     <= phase_next;
        oor_reg       <= oor_next;
        out_count_reg <= out_count_next;
        out_oor_reg   <= out_oor_next;
    end

    // land bit and parent pointer per cell
    oiuf_ram #(
        .WIDTH (WW),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### hdl/oiuf_ram.sv
// oiuf_ram: generic single-write, single-read memory with registered read
// read returns the old contents when the same address is written
// no dependencies
`default_nettype none

module oiuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
